FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PATP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PATP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/patp_pkg.sv
// ----------------------------------------------------------------------------
// patp_pkg
// Types and constants of the priority and affinity thread picker.
// ----------------------------------------------------------------------------
package patp_pkg;

    // Table geometry
    localparam int THREADS  = 16;
    localparam int CPUS     = 8;
    localparam int LEVELS   = 4;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int CPU_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CLASS_W  = 3;
    localparam int AFF_W    = 8;
    localparam int SRC_W    = 3;
    localparam int REF_W    = SLOT_W + 1;   // slot+1, zero means none
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;

    // Thread status codes
    localparam logic [STATUS_W-1:0] STAT_READY   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RUNNING = 2'd1;

    // List class of a deferred call
    localparam logic [CLASS_W-1:0] DEFER_CLASS = CLASS_W'(LEVELS);

    // Result sources
    localparam logic [SRC_W-1:0] SRC_DEFER = 3'd0;
    localparam logic [SRC_W-1:0] SRC_LIST  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_IDLE  = 3'd2;
    localparam logic [SRC_W-1:0] SRC_CUR   = 3'd3;
    localparam logic [SRC_W-1:0] SRC_NONE  = 3'd4;
    localparam logic [SRC_W-1:0] SRC_ACK   = 3'd5;

    // Register word indexes
    localparam logic [PADDR_W-3:0] REG_ENABLED = 1'b0;

    // Mutable part of a thread entry, held in the entry memory
    typedef struct packed {
        logic [CLASS_W-1:0]  list_class;
        logic [CPU_W-1:0]    owner_cpu;
        logic [STATUS_W-1:0] status;
        logic                dead;
        logic [AFF_W-1:0]    affinity;
        logic [AFF_W-1:0]    home_affinity;
    } meta_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CUR_WR  = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_DECIDE  = 6'b001000,
        ST_PICK_WR = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

endpackage

FILE: design/patp_req_if.sv
// ----------------------------------------------------------------------------
// patp_req_if
// Request channel: one word per table write, idle set or schedule request.
// ----------------------------------------------------------------------------
interface patp_req_if
    import patp_pkg::*;
#(
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CPU_W-1:0]     cpu;
    logic [SLOT_W-1:0]    slot;
    logic                 in_use;
    logic [STATUS_W-1:0]  status;
    logic                 dead;
    logic [CLASS_W-1:0]   list_class;
    logic [AFF_W-1:0]     affinity;
    logic [TIME_BITS-1:0] last_preempt;

    modport source (
        output valid, kind, cpu, slot, in_use, status, dead, list_class,
               affinity, last_preempt,
        input  ready
    );

    modport sink (
        input  valid, kind, cpu, slot, in_use, status, dead, list_class,
               affinity, last_preempt,
        output ready
    );
endinterface

FILE: design/patp_rsp_if.sv
// ----------------------------------------------------------------------------
// patp_rsp_if
// Result channel: one word per accepted request.
// ----------------------------------------------------------------------------
interface patp_rsp_if
    import patp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [SRC_W-1:0]   chosen_source;
    logic [CLASS_W-1:0] chosen_level;

    modport source (
        output valid, chosen_slot, chosen_source, chosen_level,
        input  ready
    );

    modport sink (
        input  valid, chosen_slot, chosen_source, chosen_level,
        output ready
    );
endinterface

FILE: design/patp_ram.sv
// ----------------------------------------------------------------------------
// patp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module patp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/priority_affinity_thread_picker.sv
// ----------------------------------------------------------------------------
// priority_affinity_thread_picker
// Thread table with a per-CPU scheduler: demotes the running thread, then
// picks a deferred call, the oldest thread of the highest busy level, the
// idle thread or the current thread, and pins the pick to the CPU.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  req     | in  | valid/ready          | kind, cpu, slot, entry fields, time
//  rsp     | out | valid/ready          | chosen_slot, chosen_source, chosen_level
//  apb     | in  | psel/penable, pready | enabled register at word 0
//
//  Schedule request: demote, scan of the entry memory (one entry per cycle
//  on its read port), decide, pin the pick; next accept only back in idle.
//  Table writes, idle sets and acknowledges go straight to the output word.
//  A finished word waits in the output register; ready drops while it is full
//  and the next request has finished. No clearing pass: used bits reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_affinity_thread_picker
    import patp_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    patp_req_if.sink           req,
    patp_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int META_W = $bits(meta_t);

    // Control state
    state_t               state_reg, state_next;
    logic                 enabled_reg, enabled_next;
    logic [THREADS-1:0]   used_reg, used_next;
    logic [REF_W-1:0]     cur_ref_reg [CPUS];
    logic [REF_W-1:0]     cur_ref_next [CPUS];
    logic [REF_W-1:0]     idle_ref_reg [CPUS];
    logic [REF_W-1:0]     idle_ref_next [CPUS];
    logic                 out_valid_reg, out_valid_next;
    logic                 have_cur_reg, have_cur_next;
    logic [SLOT_W:0]      scan_addr_reg, scan_addr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 defer_found_reg, defer_found_next;
    logic                 list_found_reg, list_found_next;
    logic                 cur_run_reg, cur_run_next;

    // Payload registers
    logic [CPU_W-1:0]     cpu_reg, cpu_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0]    defer_slot_reg, defer_slot_next;
    logic [SLOT_W-1:0]    list_slot_reg, list_slot_next;
    logic [CLASS_W-1:0]   list_level_reg, list_level_next;
    logic [TIME_BITS-1:0] list_time_reg, list_time_next;
    logic [CLASS_W-1:0]   cur_class_reg, cur_class_next;
    logic [CLASS_W-1:0]   idle_class_reg, idle_class_next;
    logic [SLOT_W-1:0]    pick_slot_reg, pick_slot_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [SRC_W-1:0]     res_src_reg, res_src_next;
    logic [CLASS_W-1:0]   res_level_reg, res_level_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [SRC_W-1:0]     out_src_reg, out_src_next;
    logic [CLASS_W-1:0]   out_level_reg, out_level_next;

    // Memory ports
    logic                 meta_we;
    logic [SLOT_W-1:0]    meta_waddr;
    meta_t                meta_wdata;
    logic [SLOT_W-1:0]    meta_raddr;
    meta_t                meta_rdata;
    logic                 time_we;
    logic [TIME_BITS-1:0] time_rdata;

    // Helpers
    logic                 req_fire;
    logic                 cfg_write;
    logic [REF_W-1:0]     req_ref;
    logic [REF_W-1:0]     idle_ref;
    logic [SLOT_W-1:0]    idle_slot;
    logic                 idle_ok;
    logic                 chk_run;

    assign req_fire  = req.valid && req.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign req_ref   = cur_ref_reg[req.cpu];
    assign idle_ref  = idle_ref_reg[cpu_reg];
    assign idle_slot = SLOT_W'(idle_ref - REF_W'(1));
    assign idle_ok   = (idle_ref != '0) && used_reg[idle_slot];

    // Entry under check can run on the requesting CPU
    assign chk_run = used_reg[chk_idx_reg] && meta_rdata.affinity[cpu_reg] &&
                     !meta_rdata.dead && (meta_rdata.status == STAT_READY);

    // Entry memories: mutable fields and preempt time
    patp_ram #(
        .WIDTH (META_W),
        .DEPTH (THREADS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    patp_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (THREADS)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (req.slot),
        .wdata (req.last_preempt),
        .raddr (meta_raddr),
        .rdata (time_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_ENABLED) ?
                    PDATA_W'(enabled_reg) : '0;

    always_comb
    begin
        enabled_next = enabled_reg;
        if (cfg_write && (paddr[PADDR_W-1:2] == REG_ENABLED))
        begin
            enabled_next = pwdata[0];
        end
    end

    // Handshake outputs
    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.chosen_slot    = out_slot_reg;
    assign rsp.chosen_source  = out_src_reg;
    assign rsp.chosen_level   = out_level_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        cur_ref_next     = cur_ref_reg;
        idle_ref_next    = idle_ref_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        have_cur_next    = have_cur_reg;
        scan_addr_next   = scan_addr_reg;
        chk_valid_next   = 1'b0;
        defer_found_next = defer_found_reg;
        list_found_next  = list_found_reg;
        cur_run_next     = cur_run_reg;
        cpu_next         = cpu_reg;
        cur_slot_next    = cur_slot_reg;
        chk_idx_next     = chk_idx_reg;
        defer_slot_next  = defer_slot_reg;
        list_slot_next   = list_slot_reg;
        list_level_next  = list_level_reg;
        list_time_next   = list_time_reg;
        cur_class_next   = cur_class_reg;
        idle_class_next  = idle_class_reg;
        pick_slot_next   = pick_slot_reg;
        res_slot_next    = res_slot_reg;
        res_src_next     = res_src_reg;
        res_level_next   = res_level_reg;
        out_slot_next    = out_slot_reg;
        out_src_next     = out_src_reg;
        out_level_next   = out_level_reg;
        meta_we          = 1'b0;
        meta_waddr       = cur_slot_reg;
        meta_wdata       = meta_rdata;
        meta_raddr       = scan_addr_reg[SLOT_W-1:0];
        time_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Acknowledge unless a schedule request runs
                res_slot_next  = '0;
                res_src_next   = SRC_ACK;
                res_level_next = '0;
                cpu_next       = req.cpu;
                cur_slot_next  = SLOT_W'(req_ref - REF_W'(1));
                meta_raddr     = SLOT_W'(req_ref - REF_W'(1));
                if (req_fire)
                begin
                    state_next = ST_DONE;
                    case (req.kind)
                        KIND_WRITE:
                        begin
                            meta_we                  = 1'b1;
                            meta_waddr               = req.slot;
                            meta_wdata.list_class    = req.list_class;
                            meta_wdata.owner_cpu     = req.cpu;
                            meta_wdata.status        = req.status;
                            meta_wdata.dead          = req.dead;
                            meta_wdata.affinity      = req.affinity;
                            meta_wdata.home_affinity = req.affinity;
                            time_we                  = 1'b1;
                            used_next[req.slot]      = req.in_use;
                        end
                        KIND_IDLE:
                        begin
                            idle_ref_next[req.cpu] = req.in_use ?
                                ({1'b0, req.slot} + REF_W'(1)) : '0;
                        end
                        KIND_SCHED:
                        begin
                            if (enabled_reg)
                            begin
                                have_cur_next = (req_ref != '0) &&
                                    used_reg[SLOT_W'(req_ref - REF_W'(1))];
                                state_next    = ST_CUR_WR;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CUR_WR:
            begin
                // Demote the running thread and restore its home affinity
                if (have_cur_reg)
                begin
                    meta_we             = 1'b1;
                    meta_waddr          = cur_slot_reg;
                    meta_wdata.affinity = meta_rdata.home_affinity;
                    if (meta_rdata.status == STAT_RUNNING)
                    begin
                        meta_wdata.status = STAT_READY;
                    end
                end
                scan_addr_next   = '0;
                defer_found_next = 1'b0;
                list_found_next  = 1'b0;
                cur_run_next     = 1'b0;
                state_next       = ST_SCAN;
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; check the word read last cycle
                if (scan_addr_reg != (SLOT_W + 1)'(THREADS))
                begin
                    scan_addr_next = scan_addr_reg + (SLOT_W + 1)'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_addr_reg[SLOT_W-1:0];
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
                if (chk_valid_reg)
                begin
                    if (chk_run && !defer_found_reg &&
                        (meta_rdata.list_class == DEFER_CLASS) &&
                        (meta_rdata.owner_cpu == cpu_reg))
                    begin
                        defer_found_next = 1'b1;
                        defer_slot_next  = chk_idx_reg;
                    end
                    if (chk_run && (meta_rdata.list_class < DEFER_CLASS) &&
                        (!list_found_reg || (meta_rdata.list_class > list_level_reg) ||
                         ((meta_rdata.list_class == list_level_reg) &&
                          (time_rdata < list_time_reg))))
                    begin
                        list_found_next = 1'b1;
                        list_slot_next  = chk_idx_reg;
                        list_level_next = meta_rdata.list_class;
                        list_time_next  = time_rdata;
                    end
                    if (chk_idx_reg == cur_slot_reg)
                    begin
                        cur_run_next   = chk_run;
                        cur_class_next = meta_rdata.list_class;
                    end
                    if (chk_idx_reg == idle_slot)
                    begin
                        idle_class_next = meta_rdata.list_class;
                    end
                end
            end

            ST_DECIDE:
            begin
                // Priority: deferred call, list, idle, current
                state_next = ST_PICK_WR;
                if (defer_found_reg)
                begin
                    pick_slot_next = defer_slot_reg;
                    res_src_next   = SRC_DEFER;
                    res_level_next = DEFER_CLASS;
                end
                else if (list_found_reg)
                begin
                    pick_slot_next = list_slot_reg;
                    res_src_next   = SRC_LIST;
                    res_level_next = list_level_reg;
                end
                else if (idle_ok)
                begin
                    pick_slot_next = idle_slot;
                    res_src_next   = SRC_IDLE;
                    res_level_next = idle_class_reg;
                end
                else if (have_cur_reg && cur_run_reg)
                begin
                    pick_slot_next = cur_slot_reg;
                    res_src_next   = SRC_CUR;
                    res_level_next = cur_class_reg;
                end
                else
                begin
                    res_src_next   = SRC_NONE;
                    res_level_next = '0;
                    state_next     = ST_DONE;
                end
                res_slot_next = (state_next == ST_DONE) ? '0 : pick_slot_next;
                meta_raddr    = pick_slot_next;
            end

            ST_PICK_WR:
            begin
                // Mark running, pin to the CPU, make it current
                meta_we               = 1'b1;
                meta_waddr            = pick_slot_reg;
                meta_wdata.status     = STAT_RUNNING;
                meta_wdata.affinity   = AFF_W'(1) << cpu_reg;
                cur_ref_next[cpu_reg] = {1'b0, pick_slot_reg} + REF_W'(1);
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_reg;
                    out_src_next   = res_src_reg;
                    out_level_next = res_level_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            enabled_reg     <= 1'b0;
            used_reg        <= '0;
            cur_ref_reg     <= '{default: '0};
            idle_ref_reg    <= '{default: '0};
            out_valid_reg   <= 1'b0;
            have_cur_reg    <= 1'b0;
            scan_addr_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            defer_found_reg <= 1'b0;
            list_found_reg  <= 1'b0;
            cur_run_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            enabled_reg     <= enabled_next;
            used_reg        <= used_next;
            cur_ref_reg     <= cur_ref_next;
            idle_ref_reg    <= idle_ref_next;
            out_valid_reg   <= out_valid_next;
            have_cur_reg    <= have_cur_next;
            scan_addr_reg   <= scan_addr_next;
            chk_valid_reg   <= chk_valid_next;
            defer_found_reg <= defer_found_next;
            list_found_reg  <= list_found_next;
            cur_run_reg     <= cur_run_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cpu_reg        <= cpu_next;
        cur_slot_reg   <= cur_slot_next;
        chk_idx_reg    <= chk_idx_next;
        defer_slot_reg <= defer_slot_next;
        list_slot_reg  <= list_slot_next;
        list_level_reg <= list_level_next;
        list_time_reg  <= list_time_next;
        cur_class_reg  <= cur_class_next;
        idle_class_reg <= idle_class_next;
        pick_slot_reg  <= pick_slot_next;
        res_slot_reg   <= res_slot_next;
        res_src_reg    <= res_src_next;
        res_level_reg  <= res_level_next;
        out_slot_reg   <= out_slot_next;
        out_src_reg    <= out_src_next;
        out_level_reg  <= out_level_next;
    end

    // Checks
    `PATP_ASSERT_IMPLIES(a_pick_used, state_reg == ST_PICK_WR, used_reg[pick_slot_reg], "picked slot is not in use")
    `PATP_ASSERT_IMPLIES(a_scan_no_write, state_reg == ST_SCAN, !meta_we && !time_we, "entry memory written during scan")
    `PATP_ASSERT_IMPLIES(a_none_zero, rsp.valid && rsp.chosen_source == SRC_NONE, rsp.chosen_slot == '0 && rsp.chosen_level == '0, "error word carries a slot or level")
    `PATP_ASSERT_NEXT(a_pick_current, state_reg == ST_PICK_WR, cur_ref_reg[cpu_reg] == ({1'b0, pick_slot_reg} + REF_W'(1)), "pick not made current")
    `PATP_ASSERT_NEXT(a_sched_disabled, req.valid && req.ready && req.kind == KIND_SCHED && !enabled_reg, state_reg == ST_DONE && res_src_reg == SRC_ACK, "schedule ran while disabled")

endmodule
